### rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and microcode encodings for the integer to ASCII
// converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Field widths
  localparam int VALUE_W      = 64;
  localparam int KIND_W       = 2;
  localparam int CHAR_W       = 7;
  localparam int DEC_BITS     = 32;
  localparam int BCD_DIGITS   = 10;
  localparam int BCD_W        = 4 * BCD_DIGITS;
  localparam int HEX32_DIGITS = 8;
  localparam int HEX64_DIGITS = 16;
  localparam int CNT_W        = 6;
  localparam int UPC_W        = 4;

  // Format kinds
  localparam logic [KIND_W-1:0] KIND_DEC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEX32 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HEX64 = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FIXED = 2'd3;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHR_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CHR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHR_ALPHA = 7'h37; // 'A' - 10

  typedef logic [UPC_W-1:0] upc_t;

  // Microprogram step addresses
  localparam upc_t ST_WAIT     = 4'd0;
  localparam upc_t ST_DISPATCH = 4'd1;
  localparam upc_t ST_DEC_LOAD = 4'd2;
  localparam upc_t ST_MINUS    = 4'd3;
  localparam upc_t ST_DABBLE   = 4'd4;
  localparam upc_t ST_BCD      = 4'd5;
  localparam upc_t ST_H32      = 4'd6;
  localparam upc_t ST_H64      = 4'd7;
  localparam upc_t ST_PFX0     = 4'd8;
  localparam upc_t ST_PFX1     = 4'd9;
  localparam upc_t ST_SKIP     = 4'd10;
  localparam upc_t ST_EMIT     = 4'd11;
  localparam upc_t ST_END      = 4'd12;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD_DEC,
    OP_DABBLE,
    OP_LOAD_BCD,
    OP_LOAD_H32,
    OP_LOAD_H64,
    OP_SKIP,
    OP_SHIFT
  } op_t;

  // Character source
  typedef enum logic [2:0] {
    EM_NONE,
    EM_MINUS,
    EM_ZERO,
    EM_X,
    EM_DIGIT
  } emit_t;

  // Branch conditions (taken -> target, else next step)
  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_NO_IN,
    J_KIND,
    J_POS,
    J_FIXED,
    J_LEAD,
    J_MORE
  } jmp_t;

  typedef struct packed {
    op_t   op;
    emit_t emit;
    jmp_t  jmp;
    upc_t  target;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic              hold;
    logic              cnt_one;
    logic              lead_zero;
    logic              neg;
    logic [KIND_W-1:0] kind;
  } stat_t;

  // Digit to ASCII, uppercase A-F
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {3'b000, d};
    return (d < 4'd10) ? (CHR_ZERO + dw) : (CHR_ALPHA + dw);
  endfunction

endpackage

### rtl/i2a_ucode_rom.sv
// ----------------------------------------------------------------------------
// i2a_ucode_rom
// Control store: one control word per microprogram step.
// ----------------------------------------------------------------------------
module i2a_ucode_rom import i2a_pkg::*; (
  input  upc_t  addr,
  output ctrl_t cw
);

  // Program listing
  always_comb begin
    unique case (addr)
      ST_WAIT:     cw = '{OP_ACCEPT,   EM_NONE,  J_NO_IN,  ST_WAIT};
      ST_DISPATCH: cw = '{OP_NOP,      EM_NONE,  J_KIND,   ST_WAIT};
      ST_DEC_LOAD: cw = '{OP_LOAD_DEC, EM_NONE,  J_POS,    ST_DABBLE};
      ST_MINUS:    cw = '{OP_NOP,      EM_MINUS, J_NEXT,   ST_WAIT};
      ST_DABBLE:   cw = '{OP_DABBLE,   EM_NONE,  J_MORE,   ST_DABBLE};
      ST_BCD:      cw = '{OP_LOAD_BCD, EM_NONE,  J_ALWAYS, ST_SKIP};
      ST_H32:      cw = '{OP_LOAD_H32, EM_NONE,  J_ALWAYS, ST_SKIP};
      ST_H64:      cw = '{OP_LOAD_H64, EM_NONE,  J_NEXT,   ST_WAIT};
      ST_PFX0:     cw = '{OP_NOP,      EM_ZERO,  J_NEXT,   ST_WAIT};
      ST_PFX1:     cw = '{OP_NOP,      EM_X,     J_FIXED,  ST_EMIT};
      ST_SKIP:     cw = '{OP_SKIP,     EM_NONE,  J_LEAD,   ST_SKIP};
      ST_EMIT:     cw = '{OP_SHIFT,    EM_DIGIT, J_MORE,   ST_EMIT};
      ST_END:      cw = '{OP_NOP,      EM_NONE,  J_ALWAYS, ST_WAIT};
      default:     cw = '{OP_NOP,      EM_NONE,  J_ALWAYS, ST_WAIT};
    endcase
  end

endmodule

### rtl/i2a_seq.sv
// ----------------------------------------------------------------------------
// i2a_seq
// Step counter with conditional branches and the kind dispatch.
// ----------------------------------------------------------------------------
module i2a_seq import i2a_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  ctrl_t cw,
  input  stat_t st,
  input  logic  in_valid,
  output upc_t  upc
);

  upc_t upc_r;
  upc_t upc_nxt;
  upc_t upc_inc;
  upc_t kind_tgt;

  assign upc_inc = upc_r + upc_t'(1);
  assign upc     = upc_r;

  // Entry step for each format kind
  always_comb begin
    unique case (st.kind)
      KIND_DEC:   kind_tgt = ST_DEC_LOAD;
      KIND_HEX32: kind_tgt = ST_H32;
      KIND_HEX64: kind_tgt = ST_H64;
      KIND_FIXED: kind_tgt = ST_H64;
      default:    kind_tgt = ST_WAIT;
    endcase
  end

  // Next step
  always_comb begin
    if (st.hold) begin
      upc_nxt = upc_r;
    end else begin
      unique case (cw.jmp)
        J_NEXT:   upc_nxt = upc_inc;
        J_ALWAYS: upc_nxt = cw.target;
        J_NO_IN:  upc_nxt = in_valid ? upc_inc : cw.target;
        J_KIND:   upc_nxt = kind_tgt;
        J_POS:    upc_nxt = st.neg ? upc_inc : cw.target;
        J_FIXED:  upc_nxt = (st.kind == KIND_FIXED) ? cw.target : upc_inc;
        J_LEAD:   upc_nxt = st.lead_zero ? cw.target : upc_inc;
        J_MORE:   upc_nxt = st.cnt_one ? upc_inc : cw.target;
        default:  upc_nxt = ST_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### rtl/i2a_datapath.sv
// ----------------------------------------------------------------------------
// i2a_datapath
// Operand registers, binary to BCD shifter, digit shift register and the
// output register, all driven by the current control word.
// ----------------------------------------------------------------------------
module i2a_datapath import i2a_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_t               cw,
  input  logic                in_valid,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic                out_stall,
  output stat_t               st,
  output logic                out_valid,
  output logic [CHAR_W-1:0]   out_character,
  output logic                out_last
);

  logic [VALUE_W-1:0]  val_r,  val_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [VALUE_W-1:0]  sh_r,   sh_nxt;
  logic [DEC_BITS-1:0] bin_r,  bin_nxt;
  logic [BCD_W-1:0]    bcd_r,  bcd_nxt;
  logic [CNT_W-1:0]    cnt_r,  cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r,  out_char_nxt;
  logic                out_last_r,  out_last_nxt;

  logic                      hold;
  logic                      cnt_one;
  logic                      lead_zero;
  logic [DEC_BITS-1:0]       mag;
  logic [BCD_W-1:0]          bcd_adj;
  logic [BCD_W+DEC_BITS-1:0] dd_shift;
  logic [CHAR_W-1:0]         ch;

  // Add 3 to every BCD digit of 5 or more before the shift
  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  // Status
  assign hold      = (cw.emit != EM_NONE) && out_valid_r && out_stall;
  assign cnt_one   = (cnt_r == CNT_W'(1));
  assign lead_zero = (sh_r[VALUE_W-1 -: 4] == 4'd0) && !cnt_one;
  assign st        = '{hold: hold, cnt_one: cnt_one, lead_zero: lead_zero,
                       neg: val_r[DEC_BITS-1], kind: kind_r};

  // Magnitude of the signed low word; most negative value wraps to 2^31
  assign mag = val_r[DEC_BITS-1] ? (~val_r[DEC_BITS-1:0] + DEC_BITS'(1))
                                 : val_r[DEC_BITS-1:0];

  assign bcd_adj  = dabble_adj(bcd_r);
  assign dd_shift = {bcd_adj, bin_r} << 1;

  // Operand and digit registers
  always_comb begin
    val_nxt  = val_r;
    kind_nxt = kind_r;
    sh_nxt   = sh_r;
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    unique case (cw.op)
      OP_NOP: begin
      end
      OP_ACCEPT: begin
        if (in_valid) begin
          val_nxt  = in_value;
          kind_nxt = in_kind;
        end
      end
      OP_LOAD_DEC: begin
        bin_nxt = mag;
        bcd_nxt = '0;
        cnt_nxt = CNT_W'(DEC_BITS);
      end
      OP_DABBLE: begin
        bcd_nxt = dd_shift[BCD_W+DEC_BITS-1 -: BCD_W];
        bin_nxt = dd_shift[DEC_BITS-1:0];
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      OP_LOAD_BCD: begin
        sh_nxt  = {bcd_r, {(VALUE_W-BCD_W){1'b0}}};
        cnt_nxt = CNT_W'(BCD_DIGITS);
      end
      OP_LOAD_H32: begin
        sh_nxt  = {val_r[DEC_BITS-1:0], {(VALUE_W-DEC_BITS){1'b0}}};
        cnt_nxt = CNT_W'(HEX32_DIGITS);
      end
      OP_LOAD_H64: begin
        sh_nxt  = val_r;
        cnt_nxt = CNT_W'(HEX64_DIGITS);
      end
      OP_SKIP: begin
        if (lead_zero) begin
          sh_nxt  = sh_r << 4;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_SHIFT: begin
        if (!hold) begin
          sh_nxt  = sh_r << 4;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Character select
  always_comb begin
    unique case (cw.emit)
      EM_MINUS: ch = CHR_MINUS;
      EM_ZERO:  ch = CHR_ZERO;
      EM_X:     ch = CHR_X;
      EM_DIGIT: ch = hex_char(sh_r[VALUE_W-1 -: 4]);
      default:  ch = CHR_ZERO;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if ((cw.emit != EM_NONE) && !hold) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ch;
      out_last_nxt  = (cw.emit == EM_DIGIT) && cnt_one;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    kind_r     <= kind_nxt;
    sh_r       <= sh_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

### rtl/integer_to_ascii_radix_converter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_converter_unit
// Prints one integer as ASCII characters, most significant first, in signed
// decimal, hex32, 0x-prefixed hex64 or 0x-prefixed fixed 16-digit hex.
//
//   channel  direction  ports                          request
//   in       input      in_value, in_kind              one number + kind
//   out      output     out_character, out_last        one character
//
// The decimal path first runs a binary to BCD loop over the 32-bit low word.
// One request is in flight at a time; in_stall is low only in the wait step.
// A stalled output character freezes the microprogram at the emitting step.
// Reset (rst_n low, synchronous) returns to the wait step and empties the
// output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_converter_unit import i2a_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [KIND_W-1:0]  in_kind,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  upc_t  upc;
  ctrl_t cw;
  stat_t st;

  // Control store
  i2a_ucode_rom u_rom (
    .addr (upc),
    .cw   (cw)
  );

  // Step counter
  i2a_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cw       (cw),
    .st       (st),
    .in_valid (in_valid),
    .upc      (upc)
  );

  // Datapath
  i2a_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cw            (cw),
    .in_valid      (in_valid),
    .in_value      (in_value),
    .in_kind       (in_kind),
    .out_stall     (out_stall),
    .st            (st),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // Open for a request only in the wait step
  assign in_stall = (cw.op != OP_ACCEPT);

endmodule

### rtl/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks for the integer to ASCII converter, bound to the top.
// ----------------------------------------------------------------------------
module i2a_checker import i2a_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CHAR_W-1:0]  out_character,
  input logic               out_last
);

  // Stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled output character changed");

  // An accepted request keeps the input stalled through the dispatch and load steps
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("new request taken too early");

  // Only digits, A-F, minus, zero or x
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character >= 7'h30 && out_character <= 7'h39) ||
                  (out_character >= 7'h41 && out_character <= 7'h46) ||
                  out_character == CHR_MINUS || out_character == CHR_X)
    else $error("illegal output character");

  // The x of the prefix and the sign character never end a number
  a_prefix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == CHR_X || out_character == CHR_MINUS) |-> !out_last)
    else $error("prefix or sign marked last");

endmodule

bind integer_to_ascii_radix_converter_unit i2a_checker u_i2a_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_character (out_character),
  .out_last      (out_last)
);

### sim/integer_to_ascii_radix_converter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_converter_unit_test
// Self-checking bench for the integer to ASCII converter. Each number request
// is predicted into its character string when accepted. Every character that
// leaves the block is compared with the oldest pending one. Both channels
// idle at random, with one long stretch where they never idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_converter_unit_test;
  import i2a_pkg::*;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          SETTLE_CYCLES = 60;
  localparam int          RANDOM_REQUESTS = 480;
  localparam int          IDLE_PERCENT = 13;
  localparam logic [6:0]  ASC_ZERO  = 7'h30;
  localparam logic [6:0]  ASC_X     = 7'h78;
  localparam logic [6:0]  ASC_MINUS = 7'h2D;
  localparam string       DIGIT_SET = "0123456789ABCDEF";

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } glyph_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_value = '0;
  logic [KIND_W-1:0]  in_kind = KIND_DEC;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_character;
  logic               out_last;

  glyph_t pending_glyphs[$];
  glyph_t head_glyph;
  int     mismatches = 0;
  int     cycle_count = 0;
  bit     steady = 1'b0;

  integer_to_ascii_radix_converter_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_kind       (in_kind),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d characters pending",
               cycle_count, pending_glyphs.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void note_failure(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
    return 7'(DIGIT_SET[nib]);
  endfunction

  // Expected character string of one number request
  function automatic void predict_number(input logic [63:0] v, input logic [1:0] k);
    logic [6:0]  text[$];
    logic [6:0]  digits[$];
    logic [31:0] mag;
    logic [63:0] rest;
    glyph_t      g;
    case (k)
      KIND_DEC: begin
        mag = v[31:0];
        if (mag[31]) begin
          text.push_back(ASC_MINUS);
          mag = -mag;   // most negative value keeps 0x80000000 as magnitude
        end
        do begin
          digits.push_front(ASC_ZERO + 7'(mag % 32'd10));
          mag = mag / 32'd10;
        end while (mag != 0);
      end
      KIND_HEX32: begin
        rest = {32'h0, v[31:0]};
        do begin
          digits.push_front(hex_ascii(rest[3:0]));
          rest = rest >> 4;
        end while (rest != 0);
      end
      KIND_HEX64: begin
        text.push_back(ASC_ZERO);
        text.push_back(ASC_X);
        rest = v;
        do begin
          digits.push_front(hex_ascii(rest[3:0]));
          rest = rest >> 4;
        end while (rest != 0);
      end
      default: begin
        text.push_back(ASC_ZERO);
        text.push_back(ASC_X);
        rest = v;
        repeat (16) begin
          digits.push_front(hex_ascii(rest[3:0]));
          rest = rest >> 4;
        end
      end
    endcase
    foreach (digits[i]) text.push_back(digits[i]);
    foreach (text[i]) begin
      g.character = text[i];
      g.last = (i == text.size() - 1);
      pending_glyphs.push_back(g);
    end
  endfunction

  // Drives one number request and holds it until accepted
  task automatic send_number(input logic [63:0] v, input logic [1:0] k);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_kind  <= k;
    do @(posedge clk); while (in_stall);
    predict_number(v, k);
  endtask

  // Character checker and output stall generator
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_glyphs.size() == 0) begin
        note_failure($sformatf("unexpected character %h last %b", out_character, out_last));
      end else begin
        head_glyph = pending_glyphs.pop_front();
        if (out_character !== head_glyph.character || out_last !== head_glyph.last)
          note_failure($sformatf("expected char %h last %b, got char %h last %b",
                                 head_glyph.character, head_glyph.last,
                                 out_character, out_last));
      end
    end
    out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Zero in every format
  task automatic test_zero();
    send_number(64'h0, KIND_DEC);
    send_number(64'h0, KIND_HEX32);
    send_number(64'h0, KIND_HEX64);
    send_number(64'h0, KIND_FIXED);
  endtask

  // Signed decimal extremes, most negative value, ignored upper half
  task automatic test_decimal_edges();
    send_number(64'h0000_0000_7FFF_FFFF, KIND_DEC);
    send_number(64'h0000_0000_8000_0000, KIND_DEC);
    send_number(64'h0000_0000_FFFF_FFFF, KIND_DEC);
    send_number(64'h0000_0000_0000_0009, KIND_DEC);
    send_number(64'h0000_0000_0000_000A, KIND_DEC);
    send_number(64'h0000_0000_FFFF_FFF6, KIND_DEC);
    send_number(64'hFFFF_FFFF_0000_0000, KIND_DEC);
    send_number(64'hDEAD_BEEF_3B9A_CA00, KIND_DEC);
  endtask

  // Hex extremes for the three hex formats
  task automatic test_hex_edges();
    send_number(64'h0000_0000_FFFF_FFFF, KIND_HEX32);
    send_number(64'h0000_0000_0000_000F, KIND_HEX32);
    send_number(64'hFFFF_FFFF_0000_0010, KIND_HEX32);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, KIND_HEX64);
    send_number(64'h0000_0000_0000_0001, KIND_HEX64);
    send_number(64'h8000_0000_0000_0000, KIND_HEX64);
    send_number(64'h0000_0001_0000_0000, KIND_HEX64);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, KIND_FIXED);
    send_number(64'h0000_0000_0000_0001, KIND_FIXED);
    send_number(64'h0123_4567_89AB_CDEF, KIND_FIXED);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return v;
      1: return v >> $urandom_range(63);
      2: return 64'($urandom_range(20));
      default: begin
        // near the signed 32-bit limits, random upper half
        v[31:4] = $urandom_range(1) ? 28'h8000000 : 28'h7FFFFFF;
        return v;
      end
    endcase
  endfunction

  // Random numbers and formats; a middle stretch without any idling
  task automatic test_random();
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 200 && n < 320);
      send_number(random_value(), 2'($urandom_range(3)));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_zero();
    test_decimal_edges();
    test_hex_edges();
    test_random();
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_glyphs.size() != 0)
      note_failure($sformatf("%0d characters never arrived", pending_glyphs.size()));
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
